/* src/itc_pkg.sv */
`timescale 1ns / 1ps
// itc_pkg: shared constants and types for the interval task scheduler
// no dependencies; used by itc_cell and interval_task_scheduler
package itc_pkg;

    localparam int TASKS  = 10;
    localparam int CNT_W  = $clog2(TASKS + 1);
    localparam int STEP_W = (TASKS > 1) ? $clog2(TASKS) : 1;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_ADD  = 2'd1;
    localparam logic [1:0] KIND_RUN  = 2'd2;

    typedef struct packed {
        logic [7:0]  id;
        logic [31:0] interval;
        logic [31:0] stamp;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic write;
    } cell_ctrl_t;

endpackage

/* src/itc_cell.sv */
`timescale 1ns / 1ps
// itc_cell: one table entry of the scheduler chain
// depends on itc_pkg (entry_t, cell_ctrl_t)
module itc_cell
(
    input  logic                clk,
    input  itc_pkg::cell_ctrl_t ctrl,
    input  itc_pkg::entry_t     shift_in,
    input  itc_pkg::entry_t     wr_data,
    output itc_pkg::entry_t     q
);

    itc_pkg::entry_t entry_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            entry_reg <= shift_in;
        end
        else if (ctrl.write)
        begin
            entry_reg <= wr_data;
        end
    end

    assign q = entry_reg;

endmodule

/* src/interval_task_scheduler.sv */
`timescale 1ns / 1ps
// interval_task_scheduler: tick counter plus a rotating chain of task cells
// depends on itc_pkg and itc_cell
//
// Usage: an item is taken at a clock edge with start high and busy low.
// kind selects tick, add or run; task_id and interval matter for add only.
// Each result beat appears for one cycle with result_valid high; the
// receiver cannot stall, so every beat must be taken when shown.
// Tick: no result, busy stays low.
// Add: its single beat (last = 1) shows in the next cycle,
// busy stays low, so another item may follow at once.
// Run: busy from the accept edge until the pass closes. The cell chain
// rotates once all the way round, one entry through the due check at the
// head per cycle, and a flush state then closes the pass. Fired beats
// trail the check by one entry; the final beat carries last = 1, or is an
// empty filler if nothing fired.
// Reset clears the tick counter, the entry count and all control state;
// the cells hold no valid bits and are only read below the entry count.
module interval_task_scheduler
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [7:0]  task_id,
    input  logic [31:0] interval,
    output logic        result_valid,
    output logic        fired,
    output logic [7:0]  fired_id,
    output logic        accepted,
    output logic        last
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [31:0]                 tick_reg, tick_next;
    logic [itc_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [itc_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                        pend_valid_reg, pend_valid_next;
    logic [7:0]                  pend_id_reg, pend_id_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        fired_reg, fired_next;
    logic [7:0]                  fired_id_reg, fired_id_next;
    logic                        accepted_reg, accepted_next;
    logic                        last_reg, last_next;

    logic                        shift_all;
    logic                        write_any;
    logic                        fire;
    logic                        due;
    itc_pkg::entry_t             wr_data;
    itc_pkg::entry_t             head;
    itc_pkg::entry_t             tail_in;
    itc_pkg::entry_t             cell_q [itc_pkg::TASKS];
    itc_pkg::cell_ctrl_t         cell_ctrl [itc_pkg::TASKS];

    // chain of cells, head at index 0, head re-enters at the tail, restamped if it fired
    genvar gi;
    generate
        for (gi = 0; gi < itc_pkg::TASKS; gi++)
        begin : g_cell
            assign cell_ctrl[gi].shift = shift_all;
            assign cell_ctrl[gi].write = write_any &&
                                         (count_reg == itc_pkg::CNT_W'(gi));
            if (gi == itc_pkg::TASKS - 1)
            begin : g_tail
                itc_cell u_cell
                (
                    .clk      (clk),
                    .ctrl     (cell_ctrl[gi]),
                    .shift_in (tail_in),
                    .wr_data  (wr_data),
                    .q        (cell_q[gi])
                );
            end
            else
            begin : g_body
                itc_cell u_cell
                (
                    .clk      (clk),
                    .ctrl     (cell_ctrl[gi]),
                    .shift_in (cell_q[gi + 1]),
                    .wr_data  (wr_data),
                    .q        (cell_q[gi])
                );
            end
        end
    endgenerate

    assign head = cell_q[0];
    assign due  = (tick_reg - head.stamp) >= head.interval;
    assign fire = (state_reg == S_RUN) && due &&
                  (itc_pkg::CNT_W'(step_reg) < count_reg);

    always_comb
    begin
        tail_in = head;
        if (fire)
        begin
            tail_in.stamp = tick_reg;
        end
    end

    assign wr_data.id       = task_id;
    assign wr_data.interval = interval;
    assign wr_data.stamp    = tick_reg;

    always_comb
    begin
        state_next      = state_reg;
        tick_next       = tick_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        out_valid_next  = 1'b0;
        fired_next      = 1'b0;
        fired_id_next   = 8'd0;
        accepted_next   = 1'b0;
        last_next       = 1'b0;
        shift_all       = 1'b0;
        write_any       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (kind)
                        itc_pkg::KIND_TICK:
                        begin
                            tick_next = tick_reg + 32'd1;
                        end
                        itc_pkg::KIND_ADD:
                        begin
                            out_valid_next = 1'b1;
                            last_next      = 1'b1;
                            if (count_reg < itc_pkg::CNT_W'(itc_pkg::TASKS))
                            begin
                                write_any     = 1'b1;
                                accepted_next = 1'b1;
                                count_next    = count_reg + itc_pkg::CNT_W'(1);
                            end
                        end
                        itc_pkg::KIND_RUN:
                        begin
                            state_next      = S_RUN;
                            step_next       = '0;
                            pend_valid_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RUN:
            begin
                shift_all = 1'b1;
                if (fire)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        fired_next     = 1'b1;
                        fired_id_next  = pend_id_reg;
                    end
                    pend_valid_next = 1'b1;
                    pend_id_next    = head.id;
                end
                if (step_reg == itc_pkg::STEP_W'(itc_pkg::TASKS - 1))
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    step_next = step_reg + itc_pkg::STEP_W'(1);
                end
            end
            S_FLUSH:
            begin
                out_valid_next = 1'b1;
                last_next      = 1'b1;
                fired_next     = pend_valid_reg;
                fired_id_next  = pend_valid_reg ? pend_id_reg : 8'd0;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tick_reg       <= 32'd0;
            count_reg      <= '0;
            step_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            fired_reg      <= 1'b0;
            fired_id_reg   <= 8'd0;
            accepted_reg   <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            count_reg      <= count_next;
            step_reg       <= step_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            fired_reg      <= fired_next;
            fired_id_reg   <= fired_id_next;
            accepted_reg   <= accepted_next;
            last_reg       <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_id_reg <= pend_id_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign fired        = fired_reg;
    assign fired_id     = fired_id_reg;
    assign accepted     = accepted_reg;
    assign last         = last_reg;

    // closing a pass always gives the final beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH) |=> (result_valid && last))
        else $error("run pass ended without a last beat");

    // beats that are not last only come out of a run pass
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> (busy && fired))
        else $error("non-final beat outside a run pass");

    // an add gives exactly one beat in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == itc_pkg::KIND_ADD))
        |=> (result_valid && last && !fired))
        else $error("add item without its beat");

    // entry count never passes the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= itc_pkg::CNT_W'(itc_pkg::TASKS))
        else $error("entry count overflow");

endmodule
